/* hw/rtl/text_console_glyph_renderer_defines.svh */
// ----------------------------------------------------------------------------
// Text console glyph renderer: assertion macros
// Concurrent assertion helpers used by the renderer's back end.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_GLYPH_RENDERER_DEFINES_SVH
`define TEXT_CONSOLE_GLYPH_RENDERER_DEFINES_SVH

`ifndef SYNTHESIS
`define TCGR_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tcgr assertion failed");
`define TCGR_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("tcgr forbidden condition seen");
`else
`define TCGR_ASSERT(label, clk, rst_n, prop)
`define TCGR_ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

/* hw/rtl/tcgr_pkg.sv */
// ----------------------------------------------------------------------------
// Text console glyph renderer package
// Shared field widths, character codes and the job word passed from the
// front end to the drawing back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tcgr_pkg;

  localparam int X_W         = 10;
  localparam int Y_W         = 9;
  localparam int CODE_W      = 8;
  localparam int FADDR_W     = 11;
  localparam int FDATA_W     = 8;
  localparam int ROW_W       = 4;
  localparam int GLYPH_ROWS  = 16;
  localparam int TDATA_W     = 32;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;
  localparam int QUEUE_CW    = 3;

  localparam logic [CODE_W-1:0] CODE_FIRST   = 8'd32;
  localparam logic [CODE_W-1:0] CODE_LAST    = 8'd126;
  localparam logic [CODE_W-1:0] CODE_NEWLINE = 8'd10;

  localparam logic [X_W-1:0]   GLYPH_COLS = 10'd8;
  localparam logic [Y_W-1:0]   LINE_STEP  = 9'd16;
  localparam logic [ROW_W-1:0] ROW_LAST   = 4'd15;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_PRINT = 1'b1
  } op_t;

  // One unit of work for the back end: a font byte write or a glyph draw.
  typedef struct packed {
    op_t                kind;
    logic [CODE_W-1:0]  code;
    logic [FADDR_W-1:0] addr;
    logic [FDATA_W-1:0] data;
    logic [X_W-1:0]     x;
    logic [Y_W-1:0]     y;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } job_slot_t;

endpackage

`default_nettype wire

/* hw/rtl/tcgr_front.sv */
// ----------------------------------------------------------------------------
// Text console glyph renderer: front end
// Accepts input words, tracks the text cursor and queues font writes and
// glyph draws for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcgr_front #(
  parameter int CONSOLE_WIDTH  = 640,
  parameter int CONSOLE_HEIGHT = 480
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // [7:0] char_code, [18:8] font_address, [26:19] font_data, rest zero
  input  wire logic [tcgr_pkg::TDATA_W-1:0] in_tdata,
  // [0] operation
  input  wire logic                  in_tuser,
  input  wire logic                  queue_full,
  output tcgr_pkg::job_slot_t        push
);
  import tcgr_pkg::*;

  localparam logic [X_W-1:0] WIDTH_X  = X_W'(CONSOLE_WIDTH);
  localparam logic [Y_W-1:0] HEIGHT_Y = Y_W'(CONSOLE_HEIGHT);

  logic [X_W-1:0] cursor_x_r, cursor_x_nxt;
  logic [Y_W-1:0] cursor_y_r, cursor_y_nxt;

  logic               accept;
  op_t                op;
  logic [CODE_W-1:0]  code;
  logic               wrap;
  logic [X_W-1:0]     draw_x;
  logic [Y_W-1:0]     draw_y;

  assign in_tready = !queue_full;
  assign accept    = in_tvalid && in_tready;
  assign op        = op_t'(in_tuser);
  assign code      = in_tdata[7:0];

  // A glyph at or past the right edge starts on the next text line.
  assign wrap   = cursor_x_r >= WIDTH_X;
  assign draw_x = wrap ? '0 : cursor_x_r;
  assign draw_y = wrap ? cursor_y_r + LINE_STEP : cursor_y_r;

  always_comb begin
    cursor_x_nxt   = cursor_x_r;
    cursor_y_nxt   = cursor_y_r;
    push.valid     = 1'b0;
    push.job.kind  = op;
    push.job.code  = code;
    push.job.addr  = in_tdata[18:8];
    push.job.data  = in_tdata[26:19];
    push.job.x     = draw_x;
    push.job.y     = draw_y;
    if (accept) begin
      case (op)
        OP_LOAD: begin
          // The font store covers the whole 11-bit address range only with FONT_DEPTH 2048.
          push.valid = 1'b1;
        end
        OP_PRINT: begin
          if (cursor_y_r < HEIGHT_Y) begin
            if (code inside {[CODE_FIRST:CODE_LAST]}) begin
              push.valid   = 1'b1;
              cursor_y_nxt = draw_y;
              cursor_x_nxt = (draw_x < WIDTH_X) ? draw_x + GLYPH_COLS : draw_x;
            end else if (code == CODE_NEWLINE) begin
              cursor_x_nxt = '0;
              cursor_y_nxt = cursor_y_r + LINE_STEP;
            end
          end
        end
        default: begin
          push.valid = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_x_r <= '0;
      cursor_y_r <= '0;
    end else begin
      cursor_x_r <= cursor_x_nxt;
      cursor_y_r <= cursor_y_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/tcgr_queue.sv */
// ----------------------------------------------------------------------------
// Text console glyph renderer: job queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcgr_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire tcgr_pkg::job_slot_t  push,
  output logic                      full,
  output tcgr_pkg::job_slot_t       head,
  input  wire logic                 pop
);
  import tcgr_pkg::*;

  job_t                entry_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CW-1:0] count_r, count_nxt;
  logic                do_push;
  logic                do_pop;

  assign full       = count_r == QUEUE_CW'(QUEUE_DEPTH);
  assign head.valid = count_r != '0;
  assign head.job   = entry_r[rd_ptr_r];

  assign do_push = push.valid && !full;
  assign do_pop  = pop && head.valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push.job;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/tcgr_back.sv */
// ----------------------------------------------------------------------------
// Text console glyph renderer: back end
// Holds the font memory, carries out font writes and reads sixteen glyph
// rows per drawn character into the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "text_console_glyph_renderer_defines.svh"

module tcgr_back #(
  parameter int FONT_DEPTH = 2048
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire tcgr_pkg::job_slot_t  head,
  output logic                      pop,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  // [9:0] pixel_x, [18:10] pixel_y, [26:19] row_bits, rest zero
  output logic [tcgr_pkg::TDATA_W-1:0] out_tdata,
  output logic                      out_tlast
);
  import tcgr_pkg::*;

  localparam int FONT_AW = $clog2(FONT_DEPTH);

  logic [FDATA_W-1:0] font_mem [FONT_DEPTH];

  logic [ROW_W-1:0]   row_r, row_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [X_W-1:0]     out_x_r;
  logic [Y_W-1:0]     out_y_r;
  logic [FDATA_W-1:0] out_bits_r;
  logic               out_last_r;

  logic               out_free;
  logic               mem_we;
  logic               mem_re;
  logic [FONT_AW-1:0] wr_addr;
  logic [FONT_AW-1:0] rd_addr;

  assign out_free = !out_valid_r || out_tready;
  assign mem_we   = head.valid && (head.job.kind == OP_LOAD);
  // A row is read only when the output register can take it.
  assign mem_re   = head.valid && (head.job.kind == OP_PRINT) && out_free;
  assign pop      = mem_we || (mem_re && (row_r == ROW_LAST));

  assign wr_addr = FONT_AW'(head.job.addr);
  assign rd_addr = FONT_AW'({head.job.code, row_r});

  assign row_nxt       = mem_re ? row_r + 1'b1 : row_r;
  assign out_valid_nxt = mem_re || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      font_mem[wr_addr] <= head.job.data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      out_bits_r <= font_mem[rd_addr];
      out_x_r    <= head.job.x;
      out_y_r    <= head.job.y + Y_W'(row_r);
      out_last_r <= row_r == ROW_LAST;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_bits_r, out_y_r, out_x_r};
  assign out_tlast  = out_last_r;

  `TCGR_ASSERT_NEVER(a_single_port, clk, rst_n, mem_we && mem_re)
  `TCGR_ASSERT(a_pop_has_job, clk, rst_n, pop |-> head.valid)
  `TCGR_ASSERT(a_read_fills_out, clk, rst_n, mem_re |=> out_valid_r)
  `TCGR_ASSERT(a_row_idle_on_load, clk, rst_n, mem_we |=> $stable(row_r))

endmodule

`default_nettype wire

/* hw/rtl/text_console_glyph_renderer.sv */
// ----------------------------------------------------------------------------
// Text console glyph renderer
// 8x16 text-mode console: font loading and character rendering into rows.
// ----------------------------------------------------------------------------
// A font write stores one byte; a printable character is read out of the
// single-port font memory one glyph row per cycle while the output register
// can take a row, and gives sixteen row words with tlast on the sixteenth.
// Line feeds, dropped codes and prints past the bottom only move or keep the
// cursor in the front end and cost the back end nothing. A four-entry queue
// lets the front end keep taking words while the back end drains rows.
// Font bytes that were never written read back as arbitrary values.
`timescale 1ns / 1ps
`default_nettype none

module text_console_glyph_renderer #(
  parameter int CONSOLE_WIDTH  = 640,
  parameter int CONSOLE_HEIGHT = 480,
  parameter int FONT_DEPTH     = 2048
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // [7:0] char_code, [18:8] font_address, [26:19] font_data, rest zero
  input  wire logic [tcgr_pkg::TDATA_W-1:0]  in_tdata,
  // [0] operation
  input  wire logic                          in_tuser,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // [9:0] pixel_x, [18:10] pixel_y, [26:19] row_bits, rest zero
  output logic [tcgr_pkg::TDATA_W-1:0]       out_tdata,
  output logic                               out_tlast
);
  import tcgr_pkg::*;

  job_slot_t push;
  job_slot_t head;
  logic      queue_full;
  logic      pop;

  tcgr_front #(
    .CONSOLE_WIDTH  (CONSOLE_WIDTH),
    .CONSOLE_HEIGHT (CONSOLE_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .queue_full (queue_full),
    .push       (push)
  );

  tcgr_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (queue_full),
    .head  (head),
    .pop   (pop)
  );

  tcgr_back #(
    .FONT_DEPTH (FONT_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

/* dv/tcgr_row_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph row checker for the text console renderer
// Watches the input and row channels. Each accepted input word updates a
// private font store and text cursor, and every printable character above
// the bottom edge queues the sixteen glyph rows it should produce. Each
// accepted row word is compared field by field with the oldest queued row.
// ----------------------------------------------------------------------------
module tcgr_row_checker #(
  parameter int CONSOLE_WIDTH  = 640,
  parameter int CONSOLE_HEIGHT = 480,
  parameter int FONT_DEPTH     = 2048
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  input  wire logic                         in_tready,
  input  wire logic [tcgr_pkg::TDATA_W-1:0] in_tdata,
  input  wire logic                         in_tuser,
  input  wire logic                         out_tvalid,
  input  wire logic                         out_tready,
  input  wire logic [tcgr_pkg::TDATA_W-1:0] out_tdata,
  input  wire logic                         out_tlast,
  output int                                mismatch_count,
  output int                                rows_pending,
  output logic [tcgr_pkg::X_W-1:0]          console_x,
  output logic [tcgr_pkg::Y_W-1:0]          console_y
);
  import tcgr_pkg::*;

  typedef struct packed {
    logic [X_W-1:0]     x;
    logic [Y_W-1:0]     y;
    logic [FDATA_W-1:0] bits;
    logic               last;
  } glyph_row_t;

  logic [FDATA_W-1:0] font_mem [FONT_DEPTH];
  glyph_row_t         rows_due [$];
  glyph_row_t         next_row;
  glyph_row_t         seen_row;

  initial begin
    mismatch_count = 0;
    rows_pending   = 0;
    console_x      = '0;
    console_y      = '0;
  end

  task automatic predict_glyph_rows(input op_t op, input logic [CODE_W-1:0] code,
                                    input logic [FADDR_W-1:0] addr,
                                    input logic [FDATA_W-1:0] data);
    glyph_row_t r;
    if (op == OP_LOAD) begin
      if (int'(addr) < FONT_DEPTH) font_mem[addr] = data;
    end else if (console_y < CONSOLE_HEIGHT) begin
      if (code == CODE_NEWLINE) begin
        console_x = '0;
        console_y = console_y + LINE_STEP;
      end else if (code >= CODE_FIRST && code <= CODE_LAST) begin
        // A cursor already at the right edge wraps before the glyph is drawn.
        if (console_x >= CONSOLE_WIDTH) begin
          console_x = '0;
          console_y = console_y + LINE_STEP;
        end
        for (int row = 0; row < GLYPH_ROWS; row++) begin
          r.x    = console_x;
          r.y    = console_y + Y_W'(row);
          r.bits = font_mem[(int'(code) * GLYPH_ROWS + row) % FONT_DEPTH];
          r.last = (row == GLYPH_ROWS - 1);
          rows_due.push_back(r);
        end
        if (console_x < CONSOLE_WIDTH) console_x = console_x + GLYPH_COLS;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      console_x = '0;
      console_y = '0;
      rows_due.delete();
    end else begin
      if (in_tvalid && in_tready)
        predict_glyph_rows(op_t'(in_tuser), in_tdata[7:0], in_tdata[18:8], in_tdata[26:19]);

      if (out_tvalid && out_tready) begin
        seen_row = {out_tdata[9:0], out_tdata[18:10], out_tdata[26:19], out_tlast};
        if (rows_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: row word with no glyph pending: x=%0d y=%0d bits=%02h last=%0b",
                     $realtime, seen_row.x, seen_row.y, seen_row.bits, seen_row.last);
        end else begin
          next_row = rows_due.pop_front();
          if (seen_row.x !== next_row.x || seen_row.y !== next_row.y ||
              seen_row.bits !== next_row.bits || seen_row.last !== next_row.last ||
              out_tdata[TDATA_W-1:27] !== '0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display({"%0t: row mismatch: expected x=%0d y=%0d bits=%02h last=%0b,",
                        " got x=%0d y=%0d bits=%02h last=%0b pad=%h"},
                       $realtime, next_row.x, next_row.y, next_row.bits, next_row.last,
                       seen_row.x, seen_row.y, seen_row.bits, seen_row.last,
                       out_tdata[TDATA_W-1:27]);
          end
        end
      end
    end
    rows_pending = rows_due.size();
  end

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console glyph renderer testbench
// Loads glyphs into the font store, prints directed and random text with
// line feeds and unprintable codes, fills the bottom line to force a wrap
// past the bottom edge and then prints into the full console. Both channels
// stall at random; a separate checker predicts and compares every glyph row.
// ----------------------------------------------------------------------------
module tb;
  import tcgr_pkg::*;

  localparam int CONSOLE_WIDTH  = 640;
  localparam int CONSOLE_HEIGHT = 480;
  localparam int FONT_DEPTH     = 2048;
  localparam int LAST_LINE_Y    = CONSOLE_HEIGHT - GLYPH_ROWS;
  localparam int HOLD_CYCLES    = 400;

  localparam logic [CODE_W-1:0] DIRECTED_TEXT [16] = '{
    CODE_FIRST, CODE_LAST, 8'd65, CODE_LAST, CODE_FIRST, 8'd65, CODE_LAST, 8'd65,
    CODE_NEWLINE, 8'd0, CODE_FIRST - 8'd1, CODE_LAST + 8'd1, 8'd255, 8'd9, 8'd11,
    CODE_LAST
  };

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [TDATA_W-1:0]   in_tdata   = '0;
  logic                 in_tuser   = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [TDATA_W-1:0]   out_tdata;
  logic                 out_tlast;

  int                   mismatch_count;
  int                   rows_pending;
  logic [X_W-1:0]       console_x;
  logic [Y_W-1:0]       console_y;

  logic                 hold_rows = 1'b0;
  logic [CODE_W-1:0]    ready_codes [$];
  bit                   glyph_ready [256];

  always #5 clk = ~clk;

  text_console_glyph_renderer #(
    .CONSOLE_WIDTH (CONSOLE_WIDTH),
    .CONSOLE_HEIGHT(CONSOLE_HEIGHT),
    .FONT_DEPTH    (FONT_DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  tcgr_row_checker #(
    .CONSOLE_WIDTH (CONSOLE_WIDTH),
    .CONSOLE_HEIGHT(CONSOLE_HEIGHT),
    .FONT_DEPTH    (FONT_DEPTH)
  ) i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .mismatch_count(mismatch_count),
    .rows_pending  (rows_pending),
    .console_x     (console_x),
    .console_y     (console_y)
  );

  // Called just after a falling edge; returns just after the falling edge that
  // follows the accepting rising edge, so the checker's cursor is up to date.
  task automatic send_word(input op_t op, input logic [CODE_W-1:0] code,
                           input logic [FADDR_W-1:0] addr, input logic [FDATA_W-1:0] data);
    int r;
    int gap;
    r   = $urandom_range(0, 99);
    gap = (r < 60) ? 0 : (r < 88) ? $urandom_range(1, 3) :
          (r < 97) ? $urandom_range(4, 10) : $urandom_range(20, 60);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= TDATA_W'({data, addr, code});
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic send_print(input logic [CODE_W-1:0] code);
    send_word(OP_PRINT, code, FADDR_W'($urandom), FDATA_W'($urandom));
  endtask

  task automatic send_font(input logic [FADDR_W-1:0] addr, input logic [FDATA_W-1:0] data);
    send_word(OP_LOAD, CODE_W'($urandom), addr, data);
  endtask

  // Odd rows carry the inverse of the base pattern unless the rows are random.
  task automatic load_glyph(input logic [CODE_W-1:0] code, input logic [FDATA_W-1:0] base,
                            input bit random_rows);
    for (int row = 0; row < GLYPH_ROWS; row++)
      send_font(FADDR_W'(int'(code) * GLYPH_ROWS + row),
                random_rows ? FDATA_W'($urandom) : (row % 2 ? ~base : base));
    if (!glyph_ready[code]) begin
      glyph_ready[code] = 1'b1;
      ready_codes.push_back(code);
    end
  endtask

  function automatic logic [CODE_W-1:0] pick_ready_code();
    return ready_codes[$urandom_range(0, ready_codes.size() - 1)];
  endfunction

  // Only glyphs whose sixteen rows are all loaded are ever printed.
  task automatic send_line_filler();
    int r;
    logic [CODE_W-1:0] code;
    r = $urandom_range(0, 99);
    if (r < 75) begin
      send_print(pick_ready_code());
    end else if (r < 87) begin
      send_font(FADDR_W'($urandom), FDATA_W'($urandom));
    end else begin
      do code = CODE_W'($urandom);
      while ((code >= CODE_FIRST && code <= CODE_LAST) || code == CODE_NEWLINE);
      send_print(code);
    end
  endtask

  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Receiver: alternating ready and stall spans, plus one long hold-off.
  initial begin
    int r;
    bit ready_on;
    ready_on = 1'b0;
    wait (rst_n);
    forever begin
      if (hold_rows) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_rows = 1'b0;
      end else begin
        ready_on = ~ready_on;
        r = $urandom_range(0, 99);
        out_tready <= ready_on;
        if (ready_on)
          repeat ((r < 85) ? $urandom_range(1, 8) : $urandom_range(40, 120)) @(negedge clk);
        else
          repeat ((r < 85) ? $urandom_range(1, 3) : $urandom_range(15, 50)) @(negedge clk);
      end
    end
  end

  initial begin
    int n;
    int wait_cycles;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    load_glyph(CODE_FIRST, 8'h00, 1'b0);
    load_glyph(CODE_LAST, 8'hFF, 1'b0);
    load_glyph(8'd65, 8'h55, 1'b0);
    send_font('0, 8'h00);
    send_font('1, 8'hFF);

    // The row side stops for a long while so the glyph queue backs up.
    hold_rows = 1'b1;
    foreach (DIRECTED_TEXT[i]) send_print(DIRECTED_TEXT[i]);

    while (console_y < LAST_LINE_Y) begin
      if ($urandom_range(0, 9) == 0)
        load_glyph(CODE_W'($urandom_range(CODE_FIRST, CODE_LAST)), '0, 1'b1);
      n = $urandom_range(0, 3);
      repeat (n) send_line_filler();
      send_print(CODE_NEWLINE);
    end

    // Fill the bottom line to the right edge; the next glyph wraps below it.
    while (console_y < CONSOLE_HEIGHT) send_print(pick_ready_code());

    // The console is now full: prints and line feeds are ignored.
    repeat (10) send_line_filler();
    send_print(CODE_NEWLINE);
    send_print(CODE_LAST);
    in_tvalid <= 1'b0;

    wait_cycles = 0;
    while (rows_pending != 0 && wait_cycles < 20000) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (40) @(negedge clk);

    if (mismatch_count == 0 && rows_pending == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/tcgr_pkg.sv
hw/rtl/tcgr_front.sv
hw/rtl/tcgr_queue.sv
hw/rtl/tcgr_back.sv
hw/rtl/text_console_glyph_renderer.sv
dv/tcgr_row_checker.sv
dv/tb.sv
